FILE: rtl/etfp_pkg.sv
// Shared constants, widths and fixed-point helpers for the escape-time pixel engine.
package etfp_pkg;

  // Pixel, limit and palette geometry
  localparam int PIX_W        = 10;
  localparam int IMG_W_LOG2   = 10;
  localparam int IMG_H_LOG2   = 10;
  localparam int IMAGE_WIDTH  = 1 << IMG_W_LOG2;
  localparam int IMAGE_HEIGHT = 1 << IMG_H_LOG2;
  localparam int LIMIT_W      = 10;
  localparam int MAX_LIMIT    = 1023;
  localparam int PALETTE_SIZE = 64;
  localparam int COLOR_W      = 6;
  // count*(PALETTE_SIZE-1) fits in this many bits
  localparam int NUM_W        = LIMIT_W + $clog2(PALETTE_SIZE);
  localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

  // Fixed point
  localparam int QF      = 28;
  localparam int WORD_W  = 32;
  localparam int MUL_W   = WORD_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 2 * WORD_W;
  localparam int MAG_W   = SQ_W - QF;
  localparam int MAP_P_W = MUL_W + PIX_W + 1;
  localparam int SAT_W   = 40;

  localparam logic [WORD_W-1:0] BAIL_STD    = 32'd1073741824;
  localparam logic [WORD_W-1:0] BAIL_RABBIT = 32'd540897444;
  localparam logic signed [WORD_W-1:0] RABBIT_RE = -32'sd32212255;
  localparam logic signed [WORD_W-1:0] RABBIT_IM = 32'sd201326592;

  // Register reset values
  localparam logic [LIMIT_W-1:0]       LIMIT_RST = 10'd50;
  localparam logic signed [WORD_W-1:0] EDGE_LO_RST = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] EDGE_HI_RST = 32'sd536870912;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PT_RE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PT_IM  = 3'd7;

  typedef enum logic [1:0] {
    MODE_JULIA  = 2'd0,
    MODE_MANDEL = 2'd1,
    MODE_RABBIT = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-WORD_W:0] top;
    top = v[SAT_W-1:WORD_W-1];
    if ((&top) || !(|top)) begin
      return v[WORD_W-1:0];
    end
    return v[SAT_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  endfunction

  // lo + prod / 2^sh, quotient truncated toward zero, result saturated
  function automatic logic signed [WORD_W-1:0] map_coord(
    input logic signed [WORD_W-1:0]  lo,
    input logic signed [MAP_P_W-1:0] prod,
    input int unsigned               sh
  );
    logic signed [MAP_P_W-1:0] adj;
    logic signed [MAP_P_W-1:0] q;
    adj = prod[MAP_P_W-1] ? prod + MAP_P_W'((1 << sh) - 1) : prod;
    q   = adj >>> sh;
    return sat32(SAT_W'(lo) + SAT_W'(q));
  endfunction

endpackage

FILE: rtl/escape_time_fractal_pixel.sv
// Escape-time fractal pixel engine: window mapping, z^2+c iteration and palette index.
//
// Usage: configuration registers are written on the cfg_ channel (index 0..7 in
// the order mode, limit, left, right, top, bottom, point re, point im); cfg_ready
// is always high and writes belong in idle periods. A pixel is a transfer on the
// in_ channel; one result per pixel leaves on the out_ channel.
// All arithmetic runs through one 33x33 signed multiplier under a small sequencer:
// the mapping runs through ST_MAP_X, ST_MAP_Y and ST_MAP_FIN, each iteration through
// z.re^2, z.im^2, z.re*z.im with the bailout test, and the update. A pixel that
// escapes at the bailout test then takes a restoring divide for the palette index.
// in_stall is high from the transfer until the result sits in the output
// register, so one pixel is in flight at a time; the next one can enter while
// that result still waits.
// Reset puts the configuration registers at their reset values and empties the output register.
// While out_stall is high the result holds; a finished pixel then waits in its
// last step until the output register frees up.
module escape_time_fractal_pixel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [etfp_pkg::WORD_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [etfp_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [etfp_pkg::PIX_W-1:0]         in_pixel_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [etfp_pkg::PIX_W-1:0]         out_x,
  output logic [etfp_pkg::PIX_W-1:0]         out_y,
  output logic                               out_inside_set,
  output logic [etfp_pkg::LIMIT_W-1:0]       out_iteration_count,
  output logic [etfp_pkg::COLOR_W-1:0]       out_color_index
);
  import etfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAP_X, ST_MAP_Y, ST_MAP_FIN, ST_SQ_R, ST_SQ_I, ST_TEST, ST_UPD,
    ST_DIV, ST_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  mode_t                      mode_r;
  logic [LIMIT_W-1:0]         limit_cfg_r;
  logic signed [WORD_W-1:0]   left_r, right_r, top_r, bottom_r, pt_re_r, pt_im_r;

  // Datapath registers
  logic [PIX_W-1:0]           px_r, py_r;
  logic signed [WORD_W-1:0]   zr_r, zi_r, cr_r, ci_r;
  logic [SQ_W-1:0]            sr_r, si_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [LIMIT_W-1:0]         count_r;
  logic                       inside_r;
  logic [NUM_W-1:0]           num_r;
  logic [LIMIT_W-1:0]         rem_r;
  logic [DIV_CNT_W-1:0]       div_cnt_r;

  // Output register
  logic                       out_valid_r;
  logic [PIX_W-1:0]           out_x_r, out_y_r;
  logic                       out_inside_r;
  logic [LIMIT_W-1:0]         out_count_r;
  logic [COLOR_W-1:0]         out_color_r;

  logic                       in_xfer, out_free, out_load;
  logic [LIMIT_W-1:0]         lim;
  logic signed [MUL_W-1:0]    span_x, span_y, mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [WORD_W-1:0]   map_val;
  logic [SQ_W-1:0]            sq_sum;
  logic [MAG_W-1:0]           bail;
  logic                       escaped;
  logic signed [SAT_W-1:0]    nr, ni;
  logic [LIMIT_W-1:0]         count_inc;
  logic [LIMIT_W:0]           trial;
  logic                       trial_ge;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_FIN) && out_free;

  assign lim = (32'(limit_cfg_r) > MAX_LIMIT) ? LIMIT_W'(MAX_LIMIT) : limit_cfg_r;

  // Window spans
  assign span_x = MUL_W'(right_r) - MUL_W'(left_r);
  assign span_y = MUL_W'(bottom_r) - MUL_W'(top_r);

  // Shared multiplier operand select
  always_comb begin
    mul_a = MUL_W'(zr_r);
    mul_b = MUL_W'(zr_r);
    case (state_r)
      ST_MAP_X: begin
        mul_a = span_x;
        mul_b = $signed({{(MUL_W-PIX_W){1'b0}}, px_r});
      end
      ST_MAP_Y: begin
        mul_a = span_y;
        mul_b = $signed({{(MUL_W-PIX_W){1'b0}}, py_r});
      end
      ST_SQ_I: begin
        mul_a = MUL_W'(zi_r);
        mul_b = MUL_W'(zi_r);
      end
      ST_TEST: begin
        mul_a = MUL_W'(zr_r);
        mul_b = MUL_W'(zi_r);
      end
      default: begin
        mul_a = MUL_W'(zr_r);
        mul_b = MUL_W'(zr_r);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Coordinate mapping from the previous product
  always_comb begin
    if (state_r == ST_MAP_Y) begin
      map_val = map_coord(left_r, $signed(prod_r[MAP_P_W-1:0]), IMG_W_LOG2);
    end else begin
      map_val = map_coord(top_r, $signed(prod_r[MAP_P_W-1:0]), IMG_H_LOG2);
    end
  end

  // Bailout test on the floored magnitude
  assign sq_sum  = sr_r + si_r;
  assign bail    = (mode_r == MODE_RABBIT) ? MAG_W'(BAIL_RABBIT) : MAG_W'(BAIL_STD);
  assign escaped = (sq_sum[SQ_W-1:QF] >= bail);

  // z update; squares are non-negative so floor is a plain shift
  assign nr = SAT_W'($signed({1'b0, sr_r[SQ_W-1:QF]})) - SAT_W'($signed({1'b0, si_r[SQ_W-1:QF]}))
            + SAT_W'(cr_r);
  assign ni = SAT_W'($signed(prod_r[SQ_W-1:QF-1])) + SAT_W'(ci_r);
  assign count_inc = count_r + 1'b1;

  // Restoring divide step
  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign trial_ge = (trial >= (LIMIT_W+1)'(lim));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_JULIA;
      limit_cfg_r <= LIMIT_RST;
      left_r      <= EDGE_LO_RST;
      right_r     <= EDGE_HI_RST;
      top_r       <= EDGE_LO_RST;
      bottom_r    <= EDGE_HI_RST;
      pt_re_r     <= '0;
      pt_im_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode_r      <= mode_t'(cfg_data[1:0]);
        REG_LIMIT:  limit_cfg_r <= cfg_data[LIMIT_W-1:0];
        REG_LEFT:   left_r      <= cfg_data;
        REG_RIGHT:  right_r     <= cfg_data;
        REG_TOP:    top_r       <= cfg_data;
        REG_BOTTOM: bottom_r    <= cfg_data;
        REG_PT_RE:  pt_re_r     <= cfg_data;
        REG_PT_IM:  pt_im_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Output valid: set on load from the last step, cleared once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            px_r    <= in_pixel_x;
            py_r    <= in_pixel_y;
            state_r <= ST_MAP_X;
          end
        end
        ST_MAP_X: begin
          prod_r  <= mul_p;
          state_r <= ST_MAP_Y;
        end
        ST_MAP_Y: begin
          prod_r <= mul_p;
          if (mode_r == MODE_MANDEL) begin
            zr_r <= pt_re_r;
            cr_r <= map_val;
          end else begin
            zr_r <= map_val;
            cr_r <= (mode_r == MODE_RABBIT) ? RABBIT_RE : pt_re_r;
          end
          state_r <= ST_MAP_FIN;
        end
        ST_MAP_FIN: begin
          if (mode_r == MODE_MANDEL) begin
            zi_r <= pt_im_r;
            ci_r <= map_val;
          end else begin
            zi_r <= map_val;
            ci_r <= (mode_r == MODE_RABBIT) ? RABBIT_IM : pt_im_r;
          end
          count_r <= '0;
          if (lim == '0) begin
            inside_r <= 1'b1;
            num_r    <= '0;
            state_r  <= ST_FIN;
          end else begin
            state_r <= ST_SQ_R;
          end
        end
        ST_SQ_R: begin
          sr_r    <= mul_p[SQ_W-1:0];
          state_r <= ST_SQ_I;
        end
        ST_SQ_I: begin
          si_r    <= mul_p[SQ_W-1:0];
          state_r <= ST_TEST;
        end
        ST_TEST: begin
          prod_r <= mul_p;
          if (escaped) begin
            inside_r  <= 1'b0;
            num_r     <= NUM_W'(count_r) * NUM_W'(PALETTE_SIZE - 1);
            rem_r     <= '0;
            div_cnt_r <= DIV_CNT_W'(NUM_W);
            state_r   <= ST_DIV;
          end else begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          zr_r    <= sat32(nr);
          zi_r    <= sat32(ni);
          count_r <= count_inc;
          if (count_inc == lim) begin
            inside_r <= 1'b1;
            num_r    <= '0;
            state_r  <= ST_FIN;
          end else begin
            state_r <= ST_SQ_R;
          end
        end
        ST_DIV: begin
          rem_r     <= trial_ge ? LIMIT_W'(trial - (LIMIT_W+1)'(lim)) : trial[LIMIT_W-1:0];
          num_r     <= {num_r[NUM_W-2:0], trial_ge};
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == DIV_CNT_W'(1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_x_r      <= px_r;
            out_y_r      <= py_r;
            out_inside_r <= inside_r;
            out_count_r  <= count_r;
            out_color_r  <= num_r[COLOR_W-1:0];
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_x               = out_x_r;
  assign out_y               = out_y_r;
  assign out_inside_set      = out_inside_r;
  assign out_iteration_count = out_count_r;
  assign out_color_index     = out_color_r;

endmodule
